/* rtl/core/bitmap_priority_ready_scheduler_top_assert.svh */
// Assertion macros shared by the scheduler RTL.
// Each use expects signals named clock and reset in scope.
`ifndef BITMAP_PRIORITY_READY_SCHEDULER_TOP_ASSERT_SVH
`define BITMAP_PRIORITY_READY_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication
`define BPRS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BPRS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/bprs_pkg.sv */
// ----------------------------------------------------------------------------
// bprs_pkg
// Types, sizes and helpers for the bitmap priority ready scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bprs_pkg;

   localparam int NUM_LEVELS = 16;
   localparam int NUM_TASKS  = 16;

   localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int TASK_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int CMD_W   = 2;
   localparam int FIELD_W = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_SELECT = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [FIELD_W-1:0] task_id;
      logic [FIELD_W-1:0] task_priority;
      logic [FIELD_W-1:0] current_id;
      logic [FIELD_W-1:0] current_priority;
      logic               current_running;
   } req_type;

   // registered read data for one word
   typedef struct packed {
      logic [TASK_W-1:0] head;
      logic [TASK_W-1:0] tail;
      logic [TASK_W-1:0] next;
      logic [TASK_W-1:0] prev;
      logic [LVL_W-1:0]  lvl;
   } rd_type;

   // state update for one word
   typedef struct packed {
      logic                  head_we;
      logic [LVL_W-1:0]      head_addr;
      logic [TASK_W-1:0]     head_data;
      logic                  tail_we;
      logic [LVL_W-1:0]      tail_addr;
      logic [TASK_W-1:0]     tail_data;
      logic                  next_we;
      logic [TASK_W-1:0]     next_addr;
      logic [TASK_W-1:0]     next_data;
      logic                  prev_we;
      logic [TASK_W-1:0]     prev_addr;
      logic [TASK_W-1:0]     prev_data;
      logic                  lvl_we;
      logic [TASK_W-1:0]     lvl_addr;
      logic [LVL_W-1:0]      lvl_data;
      logic [NUM_LEVELS-1:0] rdy_in;
      logic [NUM_TASKS-1:0]  queued_in;
   } wr_type;

   function automatic logic lvl_ok(logic [FIELD_W-1:0] v);
      return 32'(v) < NUM_LEVELS;
   endfunction

   function automatic logic task_ok(logic [FIELD_W-1:0] v);
      return 32'(v) < NUM_TASKS;
   endfunction

   function automatic logic [LVL_W-1:0] to_lvl(logic [FIELD_W-1:0] v);
      return LVL_W'(v);
   endfunction

   function automatic logic [TASK_W-1:0] to_task(logic [FIELD_W-1:0] v);
      return TASK_W'(v);
   endfunction

endpackage

/* rtl/core/bprs_if.sv */
// ----------------------------------------------------------------------------
// bprs_if
// Request and response channels of the scheduler, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bprs_req_if import bprs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [FIELD_W-1:0] task_id;
   logic [FIELD_W-1:0] task_priority;
   logic [FIELD_W-1:0] current_id;
   logic [FIELD_W-1:0] current_priority;
   logic               current_running;

   modport source (
      output valid, command, task_id, task_priority, current_id,
             current_priority, current_running,
      input  ready
   );

   modport sink (
      input  valid, command, task_id, task_priority, current_id,
             current_priority, current_running,
      output ready
   );
endinterface

interface bprs_rsp_if import bprs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               preempt_request;
   logic               none_ready;
   logic [FIELD_W-1:0] selected_task;
   logic [FIELD_W-1:0] selected_level;

   modport source (
      output valid, preempt_request, none_ready, selected_task, selected_level,
      input  ready
   );

   modport sink (
      input  valid, preempt_request, none_ready, selected_task, selected_level,
      output ready
   );
endinterface

/* rtl/core/bprs_store.sv */
// ----------------------------------------------------------------------------
// bprs_store
// Ready mask, queued bits, per-level head/tail and per-task link memories.
// Reads are registered and write-first, so a word read on the edge at which
// the previous word updates sees the updated value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_priority_ready_scheduler_top_assert.svh"

module bprs_store import bprs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  req_type               rd_req,
   input  logic                  sel_en,
   input  logic [LVL_W-1:0]      sel_addr,
   input  logic                  wr_go,
   input  wr_type                wr,
   output rd_type                rd_ff,
   output logic [TASK_W-1:0]     sel_head_ff,
   output logic [NUM_LEVELS-1:0] rdy_ff,
   output logic [NUM_TASKS-1:0]  queued_ff
);

   logic [TASK_W-1:0] head_mem_ff [NUM_LEVELS];
   logic [TASK_W-1:0] tail_mem_ff [NUM_LEVELS];
   logic [TASK_W-1:0] next_mem_ff [NUM_TASKS];
   logic [TASK_W-1:0] prev_mem_ff [NUM_TASKS];
   logic [LVL_W-1:0]  lvl_mem_ff  [NUM_TASKS];

   logic [LVL_W-1:0]  head_raddr;
   logic [LVL_W-1:0]  tail_raddr;
   logic [TASK_W-1:0] task_raddr;

   assign head_raddr = to_lvl(rd_req.current_priority);
   assign tail_raddr = (rd_req.command == CMD_ADD) ? to_lvl(rd_req.task_priority)
                                                   : to_lvl(rd_req.current_priority);
   assign task_raddr = to_task(rd_req.current_id);

   always_ff @(posedge clock) begin
      if (reset) begin
         rdy_ff    <= '0;
         queued_ff <= '0;
      end else if (wr_go) begin
         rdy_ff    <= wr.rdy_in;
         queued_ff <= wr.queued_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_go && wr.head_we) begin
         head_mem_ff[wr.head_addr] <= wr.head_data;
      end
      if (wr_go && wr.tail_we) begin
         tail_mem_ff[wr.tail_addr] <= wr.tail_data;
      end
      if (wr_go && wr.next_we) begin
         next_mem_ff[wr.next_addr] <= wr.next_data;
      end
      if (wr_go && wr.prev_we) begin
         prev_mem_ff[wr.prev_addr] <= wr.prev_data;
      end
      if (wr_go && wr.lvl_we) begin
         lvl_mem_ff[wr.lvl_addr] <= wr.lvl_data;
      end
      if (rd_en) begin
         rd_ff.head <= (wr_go && wr.head_we && wr.head_addr == head_raddr)
                       ? wr.head_data : head_mem_ff[head_raddr];
         rd_ff.tail <= (wr_go && wr.tail_we && wr.tail_addr == tail_raddr)
                       ? wr.tail_data : tail_mem_ff[tail_raddr];
         rd_ff.next <= (wr_go && wr.next_we && wr.next_addr == task_raddr)
                       ? wr.next_data : next_mem_ff[task_raddr];
         rd_ff.prev <= (wr_go && wr.prev_we && wr.prev_addr == task_raddr)
                       ? wr.prev_data : prev_mem_ff[task_raddr];
         rd_ff.lvl  <= (wr_go && wr.lvl_we && wr.lvl_addr == task_raddr)
                       ? wr.lvl_data : lvl_mem_ff[task_raddr];
      end
      if (sel_en) begin
         sel_head_ff <= (wr_go && wr.head_we && wr.head_addr == sel_addr)
                        ? wr.head_data : head_mem_ff[sel_addr];
      end
   end

   // an empty mask means nothing is queued, and the reverse
   `BPRS_ASSERT_IMP(a_empty_mask, rdy_ff == '0, queued_ff == '0, "mask empty with tasks queued")
   `BPRS_ASSERT_IMP(a_count, 1'b1, $countones(queued_ff) >= $countones(rdy_ff), "more levels than tasks")
   `BPRS_ASSERT_NXT(a_mask_hold, !wr_go, $stable(rdy_ff), "mask changed without an update")

endmodule

/* rtl/core/bprs_step.sv */
// ----------------------------------------------------------------------------
// bprs_step
// Command decode, queue link update and highest-level selection for one word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bprs_step import bprs_pkg::*; (
   input  req_type               req,
   input  rd_type                rd,
   input  logic [NUM_LEVELS-1:0] rdy,
   input  logic [NUM_TASKS-1:0]  queued,
   output wr_type                wr,
   output logic                  preempt,
   output logic                  none,
   output logic [LVL_W-1:0]      sel_lvl
);

   localparam logic [NUM_LEVELS-1:0] LVL_ONE  = NUM_LEVELS'(1);
   localparam logic [NUM_TASKS-1:0]  TASK_ONE = NUM_TASKS'(1);

   logic [TASK_W-1:0] tid;
   logic [TASK_W-1:0] cid;
   logic [LVL_W-1:0]  tlv;
   logic [LVL_W-1:0]  clv;
   logic              add_ok;
   logic              rem_ok;
   logic              is_head;
   logic              is_tail;

   assign tid = to_task(req.task_id);
   assign cid = to_task(req.current_id);
   assign tlv = to_lvl(req.task_priority);
   assign clv = to_lvl(req.current_priority);

   assign add_ok = (req.command == CMD_ADD) && task_ok(req.task_id)
                   && lvl_ok(req.task_priority) && !queued[tid];
   assign rem_ok = (req.command == CMD_REMOVE) && task_ok(req.current_id)
                   && lvl_ok(req.current_priority) && queued[cid] && (rd.lvl == clv);

   assign is_head = (rd.head == cid);
   assign is_tail = (rd.tail == cid);

   assign preempt = add_ok && req.current_running
                    && (req.task_priority > req.current_priority);

   always_comb begin
      wr           = '0;
      wr.rdy_in    = rdy;
      wr.queued_in = queued;
      if (add_ok) begin
         if (!rdy[tlv]) begin
            wr.head_we   = 1'b1;
            wr.head_addr = tlv;
            wr.head_data = tid;
         end else begin
            wr.next_we   = 1'b1;
            wr.next_addr = rd.tail;
            wr.next_data = tid;
            wr.prev_we   = 1'b1;
            wr.prev_addr = tid;
            wr.prev_data = rd.tail;
         end
         wr.tail_we   = 1'b1;
         wr.tail_addr = tlv;
         wr.tail_data = tid;
         wr.lvl_we    = 1'b1;
         wr.lvl_addr  = tid;
         wr.lvl_data  = tlv;
         wr.rdy_in    = rdy | (LVL_ONE << tlv);
         wr.queued_in = queued | (TASK_ONE << tid);
      end else if (rem_ok) begin
         priority if (is_head && is_tail) begin
            wr.rdy_in = rdy & ~(LVL_ONE << clv);
         end else if (is_head) begin
            wr.head_we   = 1'b1;
            wr.head_addr = clv;
            wr.head_data = rd.next;
         end else if (is_tail) begin
            wr.tail_we   = 1'b1;
            wr.tail_addr = clv;
            wr.tail_data = rd.prev;
         end else begin
            wr.next_we   = 1'b1;
            wr.next_addr = rd.prev;
            wr.next_data = rd.next;
            wr.prev_we   = 1'b1;
            wr.prev_addr = rd.next;
            wr.prev_data = rd.prev;
         end
         wr.queued_in = queued & ~(TASK_ONE << cid);
      end
   end

   // highest set bit of the updated mask
   always_comb begin
      sel_lvl = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (wr.rdy_in[i]) begin
            sel_lvl = LVL_W'(i);
         end
      end
   end

   assign none = (wr.rdy_in == '0);

endmodule

/* rtl/core/bitmap_priority_ready_scheduler_top.sv */
// ----------------------------------------------------------------------------
// bitmap_priority_ready_scheduler_top
// Per-level FIFO ready queues with a ready mask; add, remove and select.
//
// Each request word yields exactly one response word: the accepting edge
// registers the word and reads the link memories, and the edge at which
// the update stage goes applies the word's update to the store and reads the
// head of the highest non-empty level into the response register. One word
// can be accepted every cycle; the link memories have one write port each
// and read-after-write is bypassed, so back-to-back words see each other's
// updates. Ready drops only while a word waits in the update stage and the
// response register is full and not being taken. There is no clearing pass
// after reset: the mask and queued bits reset, the memories do not.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_priority_ready_scheduler_top_assert.svh"

module bitmap_priority_ready_scheduler_top import bprs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   bprs_req_if.sink   req_chan,
   bprs_rsp_if.source rsp_chan
);

   req_type               req_word;
   req_type               b_req_ff;
   logic                  b_vld_ff;
   logic                  b_vld_in;
   logic                  b_go;
   logic                  acc;

   logic                  rsp_vld_ff;
   logic                  rsp_vld_in;
   logic                  rsp_pre_ff;
   logic                  rsp_none_ff;
   logic [LVL_W-1:0]      rsp_lvl_ff;

   rd_type                rd_ff;
   wr_type                wr;
   logic [TASK_W-1:0]     sel_head_ff;
   logic [NUM_LEVELS-1:0] rdy_ff;
   logic [NUM_TASKS-1:0]  queued_ff;
   logic                  preempt;
   logic                  none;
   logic [LVL_W-1:0]      sel_lvl;

   assign req_word.command          = req_chan.command;
   assign req_word.task_id          = req_chan.task_id;
   assign req_word.task_priority    = req_chan.task_priority;
   assign req_word.current_id       = req_chan.current_id;
   assign req_word.current_priority = req_chan.current_priority;
   assign req_word.current_running  = req_chan.current_running;

   assign b_go           = b_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !b_vld_ff || b_go;
   assign acc            = req_chan.valid && req_chan.ready;

   assign b_vld_in   = acc ? 1'b1 : (b_go ? 1'b0 : b_vld_ff);
   assign rsp_vld_in = b_go ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         b_vld_ff   <= b_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         b_req_ff <= req_word;
      end
      if (b_go) begin
         rsp_pre_ff  <= preempt;
         rsp_none_ff <= none;
         rsp_lvl_ff  <= sel_lvl;
      end
   end

   bprs_store u_store (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (acc),
      .rd_req      (req_word),
      .sel_en      (b_go),
      .sel_addr    (sel_lvl),
      .wr_go       (b_go),
      .wr          (wr),
      .rd_ff       (rd_ff),
      .sel_head_ff (sel_head_ff),
      .rdy_ff      (rdy_ff),
      .queued_ff   (queued_ff)
   );

   bprs_step u_step (
      .req     (b_req_ff),
      .rd      (rd_ff),
      .rdy     (rdy_ff),
      .queued  (queued_ff),
      .wr      (wr),
      .preempt (preempt),
      .none    (none),
      .sel_lvl (sel_lvl)
   );

   assign rsp_chan.valid           = rsp_vld_ff;
   assign rsp_chan.preempt_request = rsp_pre_ff;
   assign rsp_chan.none_ready      = rsp_none_ff;
   assign rsp_chan.selected_level  = FIELD_W'(rsp_lvl_ff);
   assign rsp_chan.selected_task   = rsp_none_ff ? '0 : FIELD_W'(sel_head_ff);

   `BPRS_ASSERT_NXT(a_acc_loads, acc, b_vld_ff, "accepted word lost before update stage")
   `BPRS_ASSERT_NXT(a_stage_hold, b_vld_ff && !b_go, b_vld_ff, "stalled word dropped")
   `BPRS_ASSERT_NXT(a_go_out, b_go, rsp_vld_ff, "updated word missing at output")

endmodule

/* sim/ready_queue_checker.sv */
// ----------------------------------------------------------------------------
// ready_queue_checker
// Watches the request and response channels of the scheduler. It tracks the
// per-level ready queues and the ready mask from every accepted request word,
// works out the selection that the word should yield, and compares each
// accepted response word with the oldest one still awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ready_queue_checker import bprs_pkg::*; (
   input  logic clock,
   input  logic reset,
   bprs_req_if  req_mon,
   bprs_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_words
);

   typedef struct packed {
      logic               preempt_request;
      logic               none_ready;
      logic [FIELD_W-1:0] selected_task;
      logic [FIELD_W-1:0] selected_level;
   } selection_type;

   logic [NUM_LEVELS-1:0] level_bits;
   logic [NUM_TASKS-1:0]  queued;
   logic [TASK_W-1:0]     head_of [NUM_LEVELS];
   logic [TASK_W-1:0]     tail_of [NUM_LEVELS];
   logic [TASK_W-1:0]     next_of [NUM_TASKS];
   logic [TASK_W-1:0]     prev_of [NUM_TASKS];
   logic [LVL_W-1:0]      level_of [NUM_TASKS];

   selection_type expected_selections [$];

   function automatic selection_type predict_selection(req_type w);
      selection_type     res;
      logic [TASK_W-1:0] t;
      logic [LVL_W-1:0]  lv;
      logic [TASK_W-1:0] p;
      logic [TASK_W-1:0] n;
      logic              at_head;
      logic              at_tail;
      res = '0;
      res.none_ready = 1'b1;
      if (w.command == CMD_ADD) begin
         t  = TASK_W'(w.task_id);
         lv = LVL_W'(w.task_priority);
         if (int'(w.task_id) < NUM_TASKS && int'(w.task_priority) < NUM_LEVELS
             && !queued[t]) begin
            if (!level_bits[lv]) begin
               head_of[lv] = t;
            end else begin
               next_of[tail_of[lv]] = t;
               prev_of[t] = tail_of[lv];
            end
            tail_of[lv]    = t;
            level_bits[lv] = 1'b1;
            queued[t]      = 1'b1;
            level_of[t]    = lv;
            if (w.current_running && w.task_priority > w.current_priority)
               res.preempt_request = 1'b1;
         end
      end else if (w.command == CMD_REMOVE) begin
         t  = TASK_W'(w.current_id);
         lv = LVL_W'(w.current_priority);
         if (int'(w.current_id) < NUM_TASKS && int'(w.current_priority) < NUM_LEVELS
             && queued[t] && level_of[t] == lv) begin
            at_head = head_of[lv] == t;
            at_tail = tail_of[lv] == t;
            p = prev_of[t];
            n = next_of[t];
            if (at_head && at_tail) begin
               level_bits[lv] = 1'b0;
            end else if (at_head) begin
               head_of[lv] = n;
            end else if (at_tail) begin
               tail_of[lv] = p;
            end else begin
               next_of[p] = n;
               prev_of[n] = p;
            end
            queued[t] = 1'b0;
         end
      end
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (level_bits[i] && res.none_ready) begin
            res.none_ready     = 1'b0;
            res.selected_level = FIELD_W'(i);
            res.selected_task  = FIELD_W'(head_of[i]);
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      req_type       w;
      selection_type got;
      selection_type exp_sel;
      if (reset) begin
         level_bits = '0;
         queued     = '0;
         expected_selections.delete();
         fail_count    = 0;
         pending_words = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            w.command          = req_mon.command;
            w.task_id          = req_mon.task_id;
            w.task_priority    = req_mon.task_priority;
            w.current_id       = req_mon.current_id;
            w.current_priority = req_mon.current_priority;
            w.current_running  = req_mon.current_running;
            expected_selections.push_back(predict_selection(w));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.preempt_request = rsp_mon.preempt_request;
            got.none_ready      = rsp_mon.none_ready;
            got.selected_task   = rsp_mon.selected_task;
            got.selected_level  = rsp_mon.selected_level;
            if (expected_selections.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response word: preempt %0b none %0b task %0d level %0d",
                        $time, got.preempt_request, got.none_ready,
                        got.selected_task, got.selected_level);
            end else begin
               exp_sel = expected_selections.pop_front();
               if (got !== exp_sel) begin
                  fail_count++;
                  // preempt, none, task, level
                  $display("%0t: mismatch: expected %0b %0b %0d %0d, actual %0b %0b %0d %0d",
                           $time, exp_sel.preempt_request, exp_sel.none_ready,
                           exp_sel.selected_task, exp_sel.selected_level,
                           got.preempt_request, got.none_ready,
                           got.selected_task, got.selected_level);
               end
            end
         end
         pending_words = expected_selections.size();
      end
   end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench top for the bitmap priority ready scheduler. A directed run over
// the corner cases is followed by random traffic made mostly of legal adds
// and removes, with some noise. Both channels idle at random; once the
// response side is held off for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import bprs_pkg::*; ();

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 1900;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AT      = 1300;
   localparam int CALM_FROM    = 700;
   localparam int CALM_TO      = 1000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_words;
   int   sent_count;
   int   idle_cycles;
   int   hold_left;
   bit   hold_done;

   bit               gen_queued [NUM_TASKS];
   logic [FIELD_W-1:0] gen_level [NUM_TASKS];

   bprs_req_if req_chan ();
   bprs_rsp_if rsp_chan ();

   bitmap_priority_ready_scheduler_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ready_queue_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic [FIELD_W-1:0] rnd4();
      return FIELD_W'($urandom_range(0, 15));
   endfunction

   function automatic bit calm();
      return sent_count >= CALM_FROM && sent_count < CALM_TO;
   endfunction

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] tid,
                            input logic [FIELD_W-1:0] tpri, input logic [FIELD_W-1:0] cid,
                            input logic [FIELD_W-1:0] cpri, input logic crun);
      while (!calm() && $urandom_range(0, 99) < 22) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.command          <= cmd;
      req_chan.task_id          <= tid;
      req_chan.task_priority    <= tpri;
      req_chan.current_id       <= cid;
      req_chan.current_priority <= cpri;
      req_chan.current_running  <= crun;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
      // queued set as seen by the stimulus, used to pick legal words
      if (cmd == CMD_ADD && !gen_queued[tid]) begin
         gen_queued[tid] = 1'b1;
         gen_level[tid]  = tpri;
      end else if (cmd == CMD_REMOVE && gen_queued[cid] && gen_level[cid] == cpri) begin
         gen_queued[cid] = 1'b0;
      end
   endtask

   task automatic send_random_word();
      int   pool [$];
      int   pick;
      int   r;
      logic [FIELD_W-1:0] lv;
      r = $urandom_range(0, 99);
      lv = ($urandom_range(0, 1) == 0) ? rnd4() : FIELD_W'($urandom_range(12, 15));
      if (r < 40) begin
         for (int i = 0; i < NUM_TASKS; i++) if (!gen_queued[i]) pool.push_back(i);
         if (pool.size() > 0) begin
            pick = pool[$urandom_range(0, pool.size() - 1)];
            send_word(CMD_ADD, FIELD_W'(pick), lv, rnd4(), rnd4(), 1'($urandom));
         end else begin
            send_word(CMD_SELECT, rnd4(), rnd4(), rnd4(), rnd4(), 1'($urandom));
         end
      end else if (r < 72) begin
         for (int i = 0; i < NUM_TASKS; i++) if (gen_queued[i]) pool.push_back(i);
         if (pool.size() > 0) begin
            pick = pool[$urandom_range(0, pool.size() - 1)];
            send_word(CMD_REMOVE, rnd4(), rnd4(), FIELD_W'(pick), gen_level[pick],
                      1'($urandom));
         end else begin
            send_word(CMD_SELECT, rnd4(), rnd4(), rnd4(), rnd4(), 1'($urandom));
         end
      end else if (r < 86) begin
         send_word(CMD_SELECT, rnd4(), rnd4(), rnd4(), rnd4(), 1'($urandom));
      end else if (r < 93) begin
         send_word(CMD_ADD, rnd4(), rnd4(), rnd4(), rnd4(), 1'($urandom));
      end else if (r < 97) begin
         send_word(CMD_REMOVE, rnd4(), rnd4(), rnd4(), rnd4(), 1'($urandom));
      end else begin
         send_word(CMD_UNUSED, rnd4(), rnd4(), rnd4(), rnd4(), 1'($urandom));
      end
   endtask

   // response side: random back-pressure, one long hold-off, a calm stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 0;
         hold_done      <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (!hold_done && sent_count >= HOLD_AT) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= HOLD_CYCLES;
         hold_done      <= 1'b1;
      end else if (calm()) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= 22);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("bitmap_priority_ready_scheduler_top test failed");
            $finish;
         end
      end
   end

   initial begin
      reset                     <= 1'b1;
      req_chan.valid            <= 1'b0;
      req_chan.command          <= CMD_SELECT;
      req_chan.task_id          <= '0;
      req_chan.task_priority    <= '0;
      req_chan.current_id       <= '0;
      req_chan.current_priority <= '0;
      req_chan.current_running  <= 1'b0;
      sent_count  = 0;
      for (int i = 0; i < NUM_TASKS; i++) begin
         gen_queued[i] = 1'b0;
         gen_level[i]  = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty scheduler
      send_word(CMD_SELECT, rnd4(), rnd4(), rnd4(), rnd4(), 1'b1);
      send_word(CMD_REMOVE, rnd4(), rnd4(), 4'd3, 4'd3, 1'b0);
      send_word(CMD_UNUSED, rnd4(), rnd4(), rnd4(), rnd4(), 1'b1);
      // equal level: no preempt; strictly higher and running: preempt
      send_word(CMD_ADD, 4'd0, 4'd0, 4'd9, 4'd0, 1'b1);
      send_word(CMD_ADD, 4'd15, 4'd15, 4'd0, 4'd14, 1'b1);
      send_word(CMD_ADD, 4'd5, 4'd15, 4'd0, 4'd0, 1'b0);
      send_word(CMD_ADD, 4'd15, 4'd3, 4'd0, 4'd0, 1'b1);
      send_word(CMD_ADD, 4'd7, 4'd15, 4'd15, 4'd15, 1'b1);
      send_word(CMD_SELECT, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0);
      // middle, not queued, wrong level, head, last of level
      send_word(CMD_REMOVE, rnd4(), rnd4(), 4'd5, 4'd15, 1'b1);
      send_word(CMD_REMOVE, rnd4(), rnd4(), 4'd5, 4'd15, 1'b1);
      send_word(CMD_REMOVE, rnd4(), rnd4(), 4'd15, 4'd14, 1'b0);
      send_word(CMD_REMOVE, rnd4(), rnd4(), 4'd15, 4'd15, 1'b1);
      send_word(CMD_REMOVE, rnd4(), rnd4(), 4'd7, 4'd15, 1'b1);
      send_word(CMD_UNUSED, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1);
      send_word(CMD_REMOVE, rnd4(), rnd4(), 4'd0, 4'd0, 1'b0);
      // three on one level: tail, head, then last
      send_word(CMD_ADD, 4'd1, 4'd8, 4'd0, 4'd9, 1'b1);
      send_word(CMD_ADD, 4'd2, 4'd8, 4'd0, 4'd7, 1'b1);
      send_word(CMD_ADD, 4'd3, 4'd8, 4'd0, 4'd8, 1'b1);
      send_word(CMD_REMOVE, rnd4(), rnd4(), 4'd3, 4'd8, 1'b1);
      send_word(CMD_REMOVE, rnd4(), rnd4(), 4'd1, 4'd8, 1'b1);
      send_word(CMD_REMOVE, rnd4(), rnd4(), 4'd2, 4'd8, 1'b1);
      send_word(CMD_SELECT, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1);

      for (int k = 0; k < RANDOM_WORDS; k++) send_random_word();
      req_chan.valid <= 1'b0;

      // let the checker log the last word before watching the count
      repeat (2) @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (fail_count == 0 && pending_words == 0) begin
         $display("bitmap_priority_ready_scheduler_top test passed");
      end else begin
         $display("bitmap_priority_ready_scheduler_top test failed");
      end
      $finish;
   end

endmodule
